// ----- hw/rtl/lvac_pkg.sv -----
// Package for the lag-one volume / absolute-return correlation block.
// Holds the item types, the wide-word type and the shared constants.
// No dependencies.
package lvac_pkg;

  localparam int SERIES_MAX      = 4096;
  localparam int PAIR_CAP        = SERIES_MAX - 1;
  localparam int MIN_PAIRS_W     = 12;
  localparam logic [MIN_PAIRS_W-1:0] MIN_PAIRS_RESET = 12'd3;

  // ln2 in Q0.32, and the largest Q3.20 absolute return
  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  localparam logic [22:0] ABSRET_MAX = 23'h7FFFFF;

  // multi-word arithmetic for the final correlation
  localparam int LIMB_W = 32;
  localparam int LIMBS  = 6;
  localparam int WORD_W = LIMB_W * LIMBS;

  localparam int FIFO_DEPTH = 2;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [31:0] price_sample;
    logic        price_ok;
    logic [23:0] volume_sample;
    logic        volume_ok;
    logic        series_end;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] correlation;
    logic               corr_valid;
    logic [11:0]        pairs_used;
  } result_t;

  // work handed from the front to the back
  typedef struct packed {
    logic        pair;
    logic [31:0] price;
    logic [31:0] prev_price;
    logic [23:0] prev_volume;
    logic        series_end;
  } job_t;

endpackage

// ----- hw/rtl/lvac_fifo.sv -----
// Short job queue between front and back of the correlation block.
// Depends on lvac_pkg (job_t, FIFO_DEPTH).
module lvac_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lvac_pkg::job_t  wr_job,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output lvac_pkg::job_t  rd_job
);

  localparam int PTR_W = (lvac_pkg::FIFO_DEPTH > 1) ? $clog2(lvac_pkg::FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(lvac_pkg::FIFO_DEPTH + 1);

  lvac_pkg::job_t   slots [lvac_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = (count == CNT_W'(lvac_pkg::FIFO_DEPTH));
  assign empty  = (count == '0);
  assign rd_job = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(lvac_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(lvac_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/lvac_front.sv -----
// Front of the correlation block: accepts samples, tracks the previous
// step and classifies each step as a pair or not. Depends on lvac_pkg.
module lvac_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  lvac_pkg::sample_t sample,
  input  logic              q_full,
  output logic              q_push,
  output lvac_pkg::job_t    q_job
);

  logic [31:0] prev_price;
  logic [23:0] prev_volume;
  logic        prev_usable;
  logic        have_prev;
  logic        price_good;

  assign sample_stall = q_full;
  assign q_push       = sample_valid && !q_full;
  assign price_good   = sample.price_ok && (sample.price_sample != '0);

  // job for the back
  always_comb begin
    q_job.pair        = have_prev && prev_usable && price_good;
    q_job.price       = sample.price_sample;
    q_job.prev_price  = prev_price;
    q_job.prev_volume = prev_volume;
    q_job.series_end  = sample.series_end;
  end

  // previous-step state; a series end starts fresh
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_price  <= '0;
      prev_volume <= '0;
      prev_usable <= 1'b0;
      have_prev   <= 1'b0;
    end else if (q_push) begin
      prev_price  <= sample.price_sample;
      prev_volume <= sample.volume_sample;
      prev_usable <= price_good && sample.volume_ok && !sample.series_end;
      have_prev   <= !sample.series_end;
    end
  end

endmodule

// ----- hw/rtl/lvac_mul.sv -----
// Multi-word multiplier: one 32x32 partial product per cycle, LIMBS^2 partial products.
// Result is modulo 2^WORD_W. Depends on lvac_pkg.
module lvac_mul (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  lvac_pkg::word_t a,
  input  lvac_pkg::word_t b,
  output logic            done,
  output lvac_pkg::word_t prod
);

  localparam int IDX_W = $clog2(lvac_pkg::LIMBS);
  localparam int SH_W  = $clog2(lvac_pkg::LIMB_W);

  logic                 busy;
  logic [IDX_W-1:0]     i;
  logic [IDX_W-1:0]     j;
  logic [2*lvac_pkg::LIMB_W-1:0] pp;
  logic [IDX_W:0]       ij;
  lvac_pkg::word_t      pp_sh;

  // partial product placed at its limb offset
  always_comb begin
    pp    = a[lvac_pkg::LIMB_W*i +: lvac_pkg::LIMB_W] * b[lvac_pkg::LIMB_W*j +: lvac_pkg::LIMB_W];
    ij    = {1'b0, i} + {1'b0, j};
    pp_sh = lvac_pkg::WORD_W'(pp) << {ij, SH_W'(0)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      i    <= '0;
      j    <= '0;
    end else begin
      done <= busy && (j == IDX_W'(lvac_pkg::LIMBS - 1)) && (i == IDX_W'(lvac_pkg::LIMBS - 1));
      if (!busy) begin
        if (start) begin
          busy <= 1'b1;
          i    <= '0;
          j    <= '0;
        end
      end else begin
        if (j == IDX_W'(lvac_pkg::LIMBS - 1)) begin
          j <= '0;
          if (i == IDX_W'(lvac_pkg::LIMBS - 1)) begin
            busy <= 1'b0;
          end else begin
            i <= i + 1'b1;
          end
        end else begin
          j <= j + 1'b1;
        end
      end
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (!busy && start) begin
      prod <= '0;
    end else if (busy) begin
      prod <= prod + pp_sh;
    end
  end

endmodule

// ----- hw/rtl/lvac_back.sv -----
// Back of the correlation block: log2 by repeated squaring, scaling to the
// absolute log return, the five sums, and the final exact correlation.
// Depends on lvac_pkg and lvac_mul.
module lvac_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_empty,
  input  lvac_pkg::job_t                   q_job,
  output logic                             q_pop,
  input  logic                             min_pairs_we,
  input  logic [lvac_pkg::MIN_PAIRS_W-1:0] min_pairs_wdata,
  output logic                             result_valid,
  input  logic                             result_stall,
  output lvac_pkg::result_t                result
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_NORM   = 9'b000000010,
    S_SQR    = 9'b000000100,
    S_SCALE  = 9'b000001000,
    S_ACC    = 9'b000010000,
    S_FSTART = 9'b000100000,
    S_FWAIT  = 9'b001000000,
    S_FPOST  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  typedef enum logic [3:0] {
    ST_NXX   = 4'd0,
    ST_XX    = 4'd1,
    ST_NYY   = 4'd2,
    ST_YY    = 4'd3,
    ST_NXY   = 4'd4,
    ST_XY    = 4'd5,
    ST_PROD  = 4'd6,
    ST_CC    = 4'd7,
    ST_SRCH  = 4'd8
  } step_t;

  localparam logic [31:0] LN2_LOCAL = lvac_pkg::LN2_Q32;

  state_t state;
  step_t  step;

  lvac_pkg::job_t job;
  logic [lvac_pkg::MIN_PAIRS_W-1:0] min_pairs;

  // log2 unit
  logic [31:0] lg_x;
  logic [4:0]  lg_e;
  logic [23:0] lg_f;
  logic [4:0]  lg_cnt;
  logic        lg_second;
  logic [28:0] l1;
  logic [28:0] l0;
  logic [22:0] absret;
  logic [1:0]  acc_step;

  // sums
  logic [35:0] sum_volume;
  logic [34:0] sum_absret;
  logic [59:0] sum_volume_sq;
  logic [57:0] sum_absret_sq;
  logic [58:0] sum_cross;
  logic [11:0] pair_count;

  // finish
  lvac_pkg::word_t tp, vx, vy, cc, prod, rhs, mul_a, mul_b, mres;
  logic            neg;
  logic            valid_r;
  logic [15:0]     lo, hi, mid;
  logic            mul_start;
  logic            mul_done;

  // squaring step
  logic [63:0] sq;
  logic [32:0] sq_t;
  logic        sq_bit;
  logic [23:0] f_next;
  always_comb begin
    sq     = lg_x * lg_x;
    sq_t   = sq[63:31];
    sq_bit = sq_t[32];
    f_next = {lg_f[22:0], sq_bit};
  end

  // scale |l1 - l0| by ln2 with rounding
  logic [28:0] dlog;
  logic [60:0] scaled;
  logic [61:0] rounded;
  logic [25:0] y_raw;
  always_comb begin
    dlog    = (l1 >= l0) ? l1 - l0 : l0 - l1;
    scaled  = 61'(dlog) * 61'(LN2_LOCAL);
    rounded = {1'b0, scaled} + (62'd1 << 35);
    y_raw   = rounded[61:36];
  end

  // shared 24-bit multiplier for the sums
  logic [23:0] am, bm;
  logic [47:0] pm;
  always_comb begin
    case (acc_step)
      2'd0:    begin am = job.prev_volume;  bm = job.prev_volume;  end
      2'd1:    begin am = 24'(absret);      bm = 24'(absret);      end
      default: begin am = job.prev_volume;  bm = 24'(absret);      end
    endcase
    pm = am * bm;
  end

  // search bookkeeping
  logic [16:0] mid_sum;
  logic        le;
  logic [15:0] lo_n, hi_n;
  always_comb begin
    mid_sum = {1'b0, lo} + {1'b0, hi} + 17'd1;
    le      = (mres <= rhs);
    lo_n    = le ? mid : lo;
    hi_n    = le ? hi : mid - 16'd1;
  end

  logic result_take;
  assign result_take = result_valid && !result_stall;
  assign q_pop       = (state == S_IDLE) && !q_empty;

  lvac_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mres)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_pairs <= lvac_pkg::MIN_PAIRS_RESET;
    end else if (min_pairs_we) begin
      min_pairs <= min_pairs_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step          <= ST_NXX;
      mul_start     <= 1'b0;
      result_valid  <= 1'b0;
      sum_volume    <= '0;
      sum_absret    <= '0;
      sum_volume_sq <= '0;
      sum_absret_sq <= '0;
      sum_cross     <= '0;
      pair_count    <= '0;
    end else begin
      // output register: loaded from S_OUT, emptied when taken
      if ((state == S_OUT) && (!result_valid || result_take)) begin
        result_valid <= 1'b1;
      end else if (result_take) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            job <= q_job;
            if (q_job.pair && (pair_count < 12'(lvac_pkg::PAIR_CAP))) begin
              lg_x      <= q_job.price;
              lg_e      <= 5'd31;
              lg_second <= 1'b0;
              state     <= S_NORM;
            end else if (q_job.series_end) begin
              step  <= ST_NXX;
              state <= S_FSTART;
            end
          end
        end
        // one shift a cycle until the leading one sits at bit 31
        S_NORM: begin
          if (lg_x[31]) begin
            lg_f   <= '0;
            lg_cnt <= '0;
            state  <= S_SQR;
          end else begin
            lg_x <= {lg_x[30:0], 1'b0};
            lg_e <= lg_e - 5'd1;
          end
        end
        // one fraction bit a cycle
        S_SQR: begin
          lg_f   <= f_next;
          lg_cnt <= lg_cnt + 5'd1;
          if (lg_cnt == 5'd23) begin
            if (!lg_second) begin
              l1        <= {lg_e, f_next};
              lg_x      <= job.prev_price;
              lg_e      <= 5'd31;
              lg_second <= 1'b1;
              state     <= S_NORM;
            end else begin
              l0    <= {lg_e, f_next};
              state <= S_SCALE;
            end
          end else begin
            lg_x <= sq_bit ? sq_t[32:1] : sq_t[31:0];
          end
        end
        S_SCALE: begin
          absret   <= (y_raw > 26'(lvac_pkg::ABSRET_MAX)) ? lvac_pkg::ABSRET_MAX : y_raw[22:0];
          acc_step <= 2'd0;
          state    <= S_ACC;
        end
        // three products through the shared multiplier
        S_ACC: begin
          case (acc_step)
            2'd0: sum_volume_sq <= sum_volume_sq + 60'(pm);
            2'd1: sum_absret_sq <= sum_absret_sq + 58'(pm);
            default: begin
              sum_cross  <= sum_cross + 59'(pm);
              sum_volume <= sum_volume + 36'(job.prev_volume);
              sum_absret <= sum_absret + 35'(absret);
              pair_count <= pair_count + 12'd1;
            end
          endcase
          acc_step <= acc_step + 2'd1;
          if (acc_step == 2'd2) begin
            if (job.series_end) begin
              step  <= ST_NXX;
              state <= S_FSTART;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_FSTART: begin
          unique case (step)
            ST_NXX:  begin mul_a <= lvac_pkg::WORD_W'(pair_count); mul_b <= lvac_pkg::WORD_W'(sum_volume_sq); end
            ST_XX:   begin mul_a <= lvac_pkg::WORD_W'(sum_volume); mul_b <= lvac_pkg::WORD_W'(sum_volume);    end
            ST_NYY:  begin mul_a <= lvac_pkg::WORD_W'(pair_count); mul_b <= lvac_pkg::WORD_W'(sum_absret_sq); end
            ST_YY:   begin mul_a <= lvac_pkg::WORD_W'(sum_absret); mul_b <= lvac_pkg::WORD_W'(sum_absret);    end
            ST_NXY:  begin mul_a <= lvac_pkg::WORD_W'(pair_count); mul_b <= lvac_pkg::WORD_W'(sum_cross);     end
            ST_XY:   begin mul_a <= lvac_pkg::WORD_W'(sum_volume); mul_b <= lvac_pkg::WORD_W'(sum_absret);    end
            ST_PROD: begin mul_a <= vx; mul_b <= vy; end
            ST_CC:   begin mul_a <= cc; mul_b <= cc; end
            default: begin
              mid   <= mid_sum[16:1];
              mul_a <= lvac_pkg::WORD_W'(mid_sum[16:1] * mid_sum[16:1]);
              mul_b <= prod;
            end
          endcase
          mul_start <= 1'b1;
          state     <= S_FWAIT;
        end
        S_FWAIT: begin
          mul_start <= 1'b0;
          if (mul_done) begin
            state <= S_FPOST;
          end
        end
        S_FPOST: begin
          unique case (step)
            ST_NXX, ST_NYY, ST_NXY: begin
              tp    <= mres;
              step  <= step_t'(step + 4'd1);
              state <= S_FSTART;
            end
            ST_XX: begin
              vx    <= (tp > mres) ? tp - mres : '0;
              step  <= ST_NYY;
              state <= S_FSTART;
            end
            ST_YY: begin
              vy    <= (tp > mres) ? tp - mres : '0;
              step  <= ST_NXY;
              state <= S_FSTART;
            end
            ST_XY: begin
              cc      <= (tp >= mres) ? tp - mres : mres - tp;
              neg     <= (tp < mres);
              valid_r <= (pair_count >= min_pairs) && (vx != '0) && (vy != '0);
              step    <= ST_PROD;
              if (!((pair_count >= min_pairs) && (vx != '0) && (vy != '0))) begin
                state <= S_OUT;
              end else begin
                state <= S_FSTART;
              end
            end
            ST_PROD: begin
              prod  <= mres;
              step  <= ST_CC;
              state <= S_FSTART;
            end
            ST_CC: begin
              rhs   <= mres << 30;
              lo    <= 16'd0;
              hi    <= 16'd32768;
              step  <= ST_SRCH;
              state <= S_FSTART;
            end
            default: begin
              lo <= lo_n;
              hi <= hi_n;
              if (!(lo_n < hi_n)) begin
                state <= S_OUT;
              end else begin
                state <= S_FSTART;
              end
            end
          endcase
        end
        // hand the result to the output register, then clear the series
        S_OUT: begin
          if (!result_valid || result_take) begin
            result.corr_valid <= valid_r;
            result.pairs_used <= pair_count;
            if (!valid_r) begin
              result.correlation <= '0;
            end else if (neg) begin
              result.correlation <= 16'd0 - lo;
            end else begin
              result.correlation <= (lo > 16'd32767) ? 16'sd32767 : lo;
            end
            sum_volume    <= '0;
            sum_absret    <= '0;
            sum_volume_sq <= '0;
            sum_absret_sq <= '0;
            sum_cross     <= '0;
            pair_count    <= '0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/lagged_volume_absreturn_correlation.sv -----
// Lag-one Pearson correlation of volume against absolute log return. The
// front takes one sample per cycle into a two-entry queue while the queue
// is not full; the back works one step at a time. For a step that forms a
// pair the back takes the item, runs the log2 unit on both prices (one
// normalizing shift a cycle, then 24 squarings, one a cycle, per price),
// scales the result and does three accumulation steps for the sums. The
// series end adds the exact correlation: up to 24 multi-word products of 36
// partial products each on one 32x32 multiplier, or six products when the
// result is invalid. min_pairs must be written only while the block is idle;
// the block itself does not enforce this.
// Depends on lvac_pkg, lvac_front, lvac_fifo, lvac_back.
module lagged_volume_absreturn_correlation (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  lvac_pkg::sample_t                sample,
  output logic                             result_valid,
  input  logic                             result_stall,
  output lvac_pkg::result_t                result,
  input  logic                             min_pairs_we,
  input  logic [lvac_pkg::MIN_PAIRS_W-1:0] min_pairs_wdata
);

  logic           q_push, q_full, q_pop, q_empty;
  lvac_pkg::job_t q_wr_job, q_rd_job;

  lvac_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_wr_job)
  );

  lvac_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (q_wr_job),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_job (q_rd_job)
  );

  lvac_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_job           (q_rd_job),
    .q_pop           (q_pop),
    .min_pairs_we    (min_pairs_we),
    .min_pairs_wdata (min_pairs_wdata),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result          (result)
  );

endmodule

// ----- hw/rtl/lvac_checker.sv -----
// Port-level checks for the correlation block, bound to the top level.
// Depends on lvac_pkg.
module lvac_checker (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_stall,
  input lvac_pkg::sample_t sample,
  input logic              result_valid,
  input logic              result_stall,
  input lvac_pkg::result_t result
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // a stalled sample stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_stall |=> sample_valid && $stable(sample))
    else $error("sample changed while stalled");

  // an invalid result carries a zero correlation
  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.corr_valid |-> result.correlation == 16'sd0)
    else $error("invalid result with nonzero correlation");

  // positive variance needs at least two pairs
  a_min_two: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.corr_valid |-> result.pairs_used >= 12'd2)
    else $error("valid result from fewer than two pairs");

  // nothing offered right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result offered after reset");

endmodule

bind lagged_volume_absreturn_correlation lvac_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .sample       (sample),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
